@@ design/hhl_pkg.sv @@
// Shared types and constants of the humidistat hysteresis lockout block.
package hhl_pkg;

   localparam int HUM_W   = 7;
   localparam int TEMP_W  = 8;
   localparam int MARGIN_W = 6;
   localparam int COUNT_W = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   localparam logic [MARGIN_W-1:0] ENGAGE_RESET    = MARGIN_W'(3);
   localparam logic [MARGIN_W-1:0] DISENGAGE_RESET = MARGIN_W'(3);
   localparam logic [COUNT_W-1:0]  LOCKOUT_RESET   = COUNT_W'(60000);

   typedef enum logic [1:0] {
      OP_SAMPLE = 2'd0,
      OP_TICK   = 2'd1,
      OP_STATUS = 2'd2
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_ENGAGE_MARGIN    = 2'd0,
      CSR_DISENGAGE_MARGIN = 2'd1,
      CSR_LOCKOUT_TICKS    = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic                      relay;
      logic                      lockout;
      logic [COUNT_W-1:0]        count;
      logic                      display;
      logic                      seen;
      logic [HUM_W-1:0]          last_hum;
      logic [HUM_W-1:0]          last_sp;
      logic signed [TEMP_W-1:0]  last_temp;
   } state_type;

   typedef struct packed {
      logic [MARGIN_W-1:0] engage_margin;
      logic [MARGIN_W-1:0] disengage_margin;
      logic [COUNT_W-1:0]  lockout_ticks;
   } cfg_type;

endpackage

@@ design/hhl_if.sv @@
// Channel interfaces: request, response and register write.
interface hhl_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        operation;
   logic [hhl_pkg::HUM_W-1:0]         humidity;
   logic signed [hhl_pkg::TEMP_W-1:0] temperature;
   logic [hhl_pkg::HUM_W-1:0]         setpoint;

   modport source (output valid, operation, humidity, temperature, setpoint, input ready);
   modport sink (input valid, operation, humidity, temperature, setpoint, output ready);
endinterface

interface hhl_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         relay_on;
   logic                         locked_out;
   logic                         display_changed;
   logic [hhl_pkg::COUNT_W-1:0]  lockout_remaining;

   modport source (output valid, relay_on, locked_out, display_changed, lockout_remaining,
                   input ready);
   modport sink (input valid, relay_on, locked_out, display_changed, lockout_remaining,
                 output ready);
endinterface

interface hhl_csr_if;
   logic                            valid;
   logic                            ready;
   logic [hhl_pkg::CSR_INDEX_W-1:0] index;
   logic [hhl_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ design/hhl_sample.sv @@
// Sample handling: change detection, hysteresis decision and lockout release.
module hhl_sample (
   input  hhl_pkg::state_type            cur,
   input  hhl_pkg::cfg_type              cfg,
   input  logic [hhl_pkg::HUM_W-1:0]     humidity,
   input  logic signed [hhl_pkg::TEMP_W-1:0] temperature,
   input  logic [hhl_pkg::HUM_W-1:0]     setpoint,
   output hhl_pkg::state_type            nxt
);
   import hhl_pkg::*;

   logic             first;
   logic [HUM_W:0]   engage_sum;
   logic [HUM_W:0]   release_sum;

   // sums are one bit wider than the fields so the compares never wrap
   assign engage_sum  = {1'b0, setpoint} + {{(HUM_W+1-MARGIN_W){1'b0}}, cfg.engage_margin};
   assign release_sum = {1'b0, humidity} + {{(HUM_W+1-MARGIN_W){1'b0}}, cfg.disengage_margin};
   assign first = !cur.seen;

   always_comb begin
      nxt = cur;
      if (cur.lockout && (cur.count == '0)) begin
         nxt.lockout = 1'b0;
      end
      if (first || (temperature != cur.last_temp)) begin
         nxt.last_temp = temperature;
         nxt.display   = 1'b1;
      end
      if (first || (humidity != cur.last_hum) || (setpoint != cur.last_sp)) begin
         nxt.last_hum = humidity;
         nxt.last_sp  = setpoint;
         nxt.display  = 1'b1;
         if (engage_sum < {1'b0, humidity}) begin
            if (!cur.relay && !nxt.lockout) begin
               nxt.relay = 1'b1;
            end
         end else if ({1'b0, setpoint} > release_sum) begin
            if (cur.relay) begin
               nxt.relay   = 1'b0;
               nxt.lockout = 1'b1;
               nxt.count   = cfg.lockout_ticks;
            end
         end
      end
      nxt.seen = 1'b1;
   end

endmodule

@@ design/humidistat_hysteresis_lockout.sv @@
// Top level of the humidistat relay controller with minimum off-time lockout.
//
// Channels: req_port takes one word per item (operation, humidity, temperature,
// setpoint); operation selects sample, millisecond tick or status read.
// rsp_port returns exactly one word per request: relay state, lockout state,
// pending display flag (value before a status read clears it) and the remaining
// lockout count. csr_port writes the engage margin, disengage margin and lockout
// length; it is always ready and must be used only while the block is idle, not
// enforced by the block. The response word is registered and valid in the cycle
// after the request is taken. One word per cycle while rsp_port.ready is high,
// set by the single state register update feeding the response register.
// Stall: the response register holds its word while rsp_port.ready is low; a
// new request is taken in the same cycle the held word leaves, so req_port.ready
// is low only while a word waits and the receiver is not taking it.
// Reset (synchronous): relay off, lockout active with a full 60000 tick count,
// margins 3, display flag clear, next sample counted as a change.
module humidistat_hysteresis_lockout (
   input  logic    clock,
   input  logic    reset,
   hhl_req_if.sink   req_port,
   hhl_rsp_if.source rsp_port,
   hhl_csr_if.sink   csr_port
);
   import hhl_pkg::*;

   state_type st_ff, st_in, sample_nxt;
   cfg_type   cfg_ff, cfg_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      relay_out_ff, lockout_out_ff, display_out_ff;
   logic [COUNT_W-1:0] count_out_ff;
   logic      shown;
   logic      req_take;
   logic      csr_take;
   op_type    op;

   hhl_sample u_sample (
      .cur         (st_ff),
      .cfg         (cfg_ff),
      .humidity    (req_port.humidity),
      .temperature (req_port.temperature),
      .setpoint    (req_port.setpoint),
      .nxt         (sample_nxt)
   );

   assign op           = op_type'(req_port.operation);
   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign req_take     = req_port.valid && req_port.ready;
   assign csr_port.ready = 1'b1;
   assign csr_take     = csr_port.valid;

   always_comb begin
      st_in = st_ff;
      shown = st_ff.display;
      case (op)
         OP_SAMPLE: begin
            st_in = sample_nxt;
            shown = sample_nxt.display;
         end
         OP_TICK: begin
            if (st_ff.count != '0) begin
               st_in.count = st_ff.count - COUNT_W'(1);
            end
         end
         OP_STATUS: begin
            st_in.display = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_take) begin
         case (csr_index_type'(csr_port.index))
            CSR_ENGAGE_MARGIN:    cfg_in.engage_margin    = csr_port.data[MARGIN_W-1:0];
            CSR_DISENGAGE_MARGIN: cfg_in.disengage_margin = csr_port.data[MARGIN_W-1:0];
            CSR_LOCKOUT_TICKS:    cfg_in.lockout_ticks    = csr_port.data[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign rsp_valid_in = req_take || (rsp_valid_ff && !rsp_port.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.relay     <= 1'b0;
         st_ff.lockout   <= 1'b1;
         st_ff.count     <= LOCKOUT_RESET;
         st_ff.display   <= 1'b0;
         st_ff.seen      <= 1'b0;
         st_ff.last_hum  <= '0;
         st_ff.last_sp   <= '0;
         st_ff.last_temp <= '0;
         cfg_ff.engage_margin    <= ENGAGE_RESET;
         cfg_ff.disengage_margin <= DISENGAGE_RESET;
         cfg_ff.lockout_ticks    <= LOCKOUT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            st_ff <= st_in;
         end
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload, loaded with each taken request
   always_ff @(posedge clock) begin
      if (req_take) begin
         relay_out_ff   <= st_in.relay;
         lockout_out_ff <= st_in.lockout;
         display_out_ff <= shown;
         count_out_ff   <= st_in.count;
      end
   end

   assign rsp_port.valid             = rsp_valid_ff;
   assign rsp_port.relay_on          = relay_out_ff;
   assign rsp_port.locked_out        = lockout_out_ff;
   assign rsp_port.display_changed   = display_out_ff;
   assign rsp_port.lockout_remaining = count_out_ff;

`ifndef NO_ASSERTIONS
   // engaging needs no lockout and releasing sets it, so both never hold together
   a_relay_not_locked: assert property (@(posedge clock) disable iff (reset)
      !(st_ff.relay && st_ff.lockout))
      else $error("relay engaged during lockout");

   // the display flag is only ever set by a sample
   a_display_needs_sample: assert property (@(posedge clock) disable iff (reset)
      !st_ff.seen |-> !st_ff.display)
      else $error("display flag set before any sample");

   a_word_follows_take: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("taken request produced no response word");

   a_tick_decrements: assert property (@(posedge clock) disable iff (reset)
      (req_take && (op == OP_TICK) && (st_ff.count != '0))
      |=> (st_ff.count == $past(st_ff.count) - COUNT_W'(1)))
      else $error("tick did not decrement lockout count");
`endif

endmodule
